// File: sv/dual_channel_sample_ring_buffer_unit_macros.svh
// Assertion macros for the dual channel sample ring buffer.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef DUAL_CHANNEL_SAMPLE_RING_BUFFER_UNIT_MACROS_SVH
`define DUAL_CHANNEL_SAMPLE_RING_BUFFER_UNIT_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define DCSRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define DCSRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dcsrb_pkg.sv
// Shared types, constants and pointer helpers for the sample ring buffer.
// No dependencies; used by every module of the block.
package dcsrb_pkg;

  localparam int DEPTH            = 32;
  localparam int PTR_W            = $clog2(DEPTH);
  localparam int SAMPLE_W         = 18;
  localparam int WORD_W           = 2 * SAMPLE_W;
  localparam int BYTE_W           = 8;
  localparam int OP_W             = 2;
  localparam int COUNT_W          = 5;
  localparam int SAMPLE_BYTES     = 6;
  localparam int PHASE_W          = 3;
  localparam int PARTIAL_W        = 40;

  typedef enum logic [OP_W-1:0] {
    OP_DATA  = 2'd0,
    OP_NEXT  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic                store;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] ir;
  } sample_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    if (p == ptr_t'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic ptr_t ring_count(ptr_t wr, ptr_t rd);
    logic [PTR_W:0] diff;
    diff = {1'b0, wr} - {1'b0, rd};
    if (diff[PTR_W]) begin
      diff = diff + (PTR_W + 1)'(DEPTH);
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

// File: sv/dual_channel_sample_ring_buffer_unit.sv
// Top level of the dual channel sample ring buffer.
// Depends on dcsrb_pkg, dcsrb_unpack, dcsrb_mem and the assertion macro header.
//
// Usage: the input channel (in_valid, in_ready) carries one item per byte or
// command: operation 0 feeds a FIFO byte, 1 advances the read pointer when
// samples are available, 2 flushes both pointers and the byte phase. Every
// item yields exactly one result on the output channel (out_valid,
// out_ready): the available count, the red and infrared sample at the read
// pointer (zero when empty) and a flag that the item completed a sample.
// Timing: the edge that accepts the item updates the pointers, writes the sample
// memory and reads the entry at the new read pointer into the read stage; the
// output register takes the read data from there once the output is free.
// Throughput: one item per cycle, set by the single write and read port of
// the sample memory. When the receiver stalls, one more item is taken and
// held in the read stage; further items wait until the output is taken.
// Reset clears the pointers, byte phase and handshake state; the sample
// memory itself is not cleared.
`include "dual_channel_sample_ring_buffer_unit_macros.svh"

module dual_channel_sample_ring_buffer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dcsrb_pkg::OP_W-1:0]     operation,
  input  logic [dcsrb_pkg::BYTE_W-1:0]   data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dcsrb_pkg::COUNT_W-1:0]  available_count,
  output logic [dcsrb_pkg::SAMPLE_W-1:0] red_value,
  output logic [dcsrb_pkg::SAMPLE_W-1:0] ir_value,
  output logic                           sample_stored
);
  import dcsrb_pkg::*;

  logic              accept;
  logic              step;
  logic              flush;
  sample_t           sample;
  ptr_t              wr_ptr;
  ptr_t              wr_ptr_next;
  ptr_t              rd_ptr;
  ptr_t              rd_ptr_next;
  ptr_t              cnt_next;
  logic              b_valid;
  logic              b_move;
  ptr_t              b_cnt;
  logic              b_stored;
  logic [WORD_W-1:0] rd_data;
  logic [COUNT_W+PTR_W-1:0] cnt_ext;

  assign accept = in_valid && in_ready;
  assign b_move = b_valid && (!out_valid || out_ready);
  assign in_ready = !b_valid || !out_valid || out_ready;

  always_comb begin
    step        = 1'b0;
    flush       = 1'b0;
    rd_ptr_next = rd_ptr;
    if (accept) begin
      case (op_t'(operation))
        OP_DATA: begin
          step = 1'b1;
        end
        OP_NEXT: begin
          if (ring_count(wr_ptr, rd_ptr) != '0) begin
            rd_ptr_next = ptr_inc(rd_ptr);
          end
        end
        OP_FLUSH: begin
          flush       = 1'b1;
          rd_ptr_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (flush) begin
      wr_ptr_next = '0;
    end else if (sample.store) begin
      wr_ptr_next = ptr_inc(wr_ptr);
    end
    cnt_next = ring_count(wr_ptr_next, rd_ptr_next);
  end

  dcsrb_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .flush     (flush),
    .data_byte (data_byte),
    .sample    (sample)
  );

  dcsrb_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sample.store),
    .wr_addr (wr_ptr),
    .wr_data ({sample.red, sample.ir}),
    .rd_en   (accept),
    .rd_addr (rd_ptr_next),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      b_valid <= 1'b0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_cnt    <= cnt_next;
      b_stored <= sample.store;
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, b_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      available_count <= cnt_ext[COUNT_W-1:0];
      sample_stored   <= b_stored;
      if (b_cnt != '0) begin
        red_value <= rd_data[SAMPLE_W +: SAMPLE_W];
        ir_value  <= rd_data[SAMPLE_W-1:0];
      end else begin
        red_value <= '0;
        ir_value  <= '0;
      end
    end
  end

  `DCSRB_ASSERT_NEXT(a_read_stage_moves, b_move, out_valid,
    "Read stage item did not reach the output register.")
  `DCSRB_ASSERT_NEXT(a_read_stage_holds, b_valid && out_valid && !out_ready,
    b_valid && $stable(b_cnt) && $stable(b_stored),
    "Read stage item changed while the output was stalled.")
  `DCSRB_ASSERT_NEXT(a_empty_reads_zero, b_move && (b_cnt == '0),
    (red_value == '0) && (ir_value == '0),
    "Empty ring produced a nonzero sample.")
  `DCSRB_ASSERT_NEXT(a_store_advances, sample.store, wr_ptr != $past(wr_ptr),
    "Stored sample did not advance the write pointer.")

endmodule

// File: sv/dcsrb_unpack.sv
// Byte assembler: collects six bytes per sample and splits red and infrared.
// Depends on dcsrb_pkg.
module dcsrb_unpack (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           flush,
  input  logic [dcsrb_pkg::BYTE_W-1:0]   data_byte,
  output dcsrb_pkg::sample_t             sample
);
  import dcsrb_pkg::*;

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLE_BYTES - 1);

  logic [PHASE_W-1:0]   byte_phase;
  logic [PARTIAL_W-1:0] partial_bytes;

  always_comb begin
    sample.store = step && (byte_phase == PHASE_LAST);
    sample.red   = partial_bytes[2*BYTE_W +: SAMPLE_W];
    sample.ir    = {partial_bytes[SAMPLE_W-BYTE_W-1:0], data_byte};
  end

  always_ff @(posedge clk) begin
    if (rst || flush || sample.store) begin
      byte_phase    <= '0;
      partial_bytes <= '0;
    end else if (step) begin
      byte_phase    <= byte_phase + 1'b1;
      partial_bytes <= {partial_bytes[PARTIAL_W-BYTE_W-1:0], data_byte};
    end
  end

endmodule

// File: sv/dcsrb_mem.sv
// Sample memory: one write and one registered read port, with write-to-read
// forwarding when both hit the same entry. Depends on dcsrb_pkg.
module dcsrb_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  dcsrb_pkg::ptr_t              wr_addr,
  input  logic [dcsrb_pkg::WORD_W-1:0] wr_data,
  input  logic                         rd_en,
  input  dcsrb_pkg::ptr_t              rd_addr,
  output logic [dcsrb_pkg::WORD_W-1:0] rd_data
);
  import dcsrb_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] ram_q;
  logic [WORD_W-1:0] fwd_data;
  logic              fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : ram_q;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dual_channel_sample_ring_buffer_unit: directed rows, then random
// byte streams, checked against typed rows or a predictor. Depends on dcsrb_pkg and the RTL.
module tb;
  import dcsrb_pkg::*;

  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] ir;
    logic                stored;
  } ring_view_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] b;
    bit                typed;
    ring_view_t        want;
  } stim_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation = OP_DATA;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COUNT_W-1:0]  available_count;
  logic [SAMPLE_W-1:0] red_value;
  logic [SAMPLE_W-1:0] ir_value;
  logic                sample_stored;

  int                  byte_phase = 0;
  logic [39:0]         partial = '0;
  int                  wr_idx = 0;
  int                  rd_idx = 0;
  logic [SAMPLE_W-1:0] red_mem [DEPTH];
  logic [SAMPLE_W-1:0] ir_mem [DEPTH];
  ring_view_t          pending_views [$];
  int                  mismatch_count = 0;
  bit                  idle_en = 1'b1;

  stim_row_t directed_rows [26] = '{
    '{OP_NEXT,    8'h00, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_IGNORED, 8'hFF, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_FLUSH,   8'h00, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'hFF, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'hFF, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'hFF, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'hFF, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'hFF, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'hFF, 1'b1, '{5'd1, 18'h3FFFF, 18'h3FFFF, 1'b1}},
    '{OP_DATA,    8'h00, 1'b1, '{5'd1, 18'h3FFFF, 18'h3FFFF, 1'b0}},
    '{OP_DATA,    8'h00, 1'b1, '{5'd1, 18'h3FFFF, 18'h3FFFF, 1'b0}},
    '{OP_DATA,    8'h00, 1'b1, '{5'd1, 18'h3FFFF, 18'h3FFFF, 1'b0}},
    '{OP_DATA,    8'h00, 1'b1, '{5'd1, 18'h3FFFF, 18'h3FFFF, 1'b0}},
    '{OP_DATA,    8'h00, 1'b1, '{5'd1, 18'h3FFFF, 18'h3FFFF, 1'b0}},
    '{OP_DATA,    8'h00, 1'b1, '{5'd2, 18'h3FFFF, 18'h3FFFF, 1'b1}},
    '{OP_NEXT,    8'h00, 1'b1, '{5'd1, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'h03, 1'b0, '0},
    '{OP_DATA,    8'hAA, 1'b0, '0},
    '{OP_IGNORED, 8'h5A, 1'b0, '0},
    '{OP_DATA,    8'h55, 1'b0, '0},
    '{OP_DATA,    8'hFC, 1'b0, '0},
    '{OP_DATA,    8'h01, 1'b0, '0},
    '{OP_DATA,    8'h80, 1'b0, '0},
    '{OP_DATA,    8'h12, 1'b0, '0},
    '{OP_FLUSH,   8'h00, 1'b1, '{5'd0, 18'h00000, 18'h00000, 1'b0}},
    '{OP_DATA,    8'h34, 1'b0, '0}
  };

  dual_channel_sample_ring_buffer_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .available_count (available_count),
    .red_value       (red_value),
    .ir_value        (ir_value),
    .sample_stored   (sample_stored)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Unpacks bytes into samples, tracks both ring pointers and returns the view after the item.
  task automatic predict_ring_view(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                                   output ring_view_t v);
    logic [23:0] hi_word;
    logic [23:0] lo_word;
    int          fill;
    v = '0;
    if (op == OP_DATA) begin
      if (byte_phase == SAMPLE_BYTES - 1) begin
        hi_word = partial[39:16];
        lo_word = {partial[15:0], b};
        red_mem[wr_idx] = hi_word[SAMPLE_W-1:0];
        ir_mem[wr_idx] = lo_word[SAMPLE_W-1:0];
        wr_idx = (wr_idx + 1) % DEPTH;
        byte_phase = 0;
        partial = '0;
        v.stored = 1'b1;
      end else begin
        partial = {partial[31:0], b};
        byte_phase++;
      end
    end else if (op == OP_NEXT) begin
      if (wr_idx != rd_idx) begin
        rd_idx = (rd_idx + 1) % DEPTH;
      end
    end else if (op == OP_FLUSH) begin
      wr_idx = 0;
      rd_idx = 0;
      byte_phase = 0;
      partial = '0;
    end
    fill = (wr_idx + DEPTH - rd_idx) % DEPTH;
    v.count = COUNT_W'(fill);
    if (fill != 0) begin
      v.red = red_mem[rd_idx];
      v.ir = ir_mem[rd_idx];
    end
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                           input bit typed = 1'b0, input ring_view_t want = '0);
    ring_view_t predicted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_ring_view(op, b, predicted);
    pending_views.push_back(typed ? want : predicted);
  endtask

  task automatic send_sample();
    repeat (SAMPLE_BYTES) send_item(OP_DATA, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Whole samples, with advances (next_pct percent), stray bytes, flushes and ignored codes.
  task automatic send_mix(input int actions, input int next_pct);
    int pick;
    repeat (actions) begin
      pick = $urandom_range(0, 99);
      if (pick < next_pct) begin
        send_item(OP_NEXT, BYTE_W'($urandom_range(0, 255)));
      end else if (pick < next_pct + 10) begin
        send_item(OP_DATA, BYTE_W'($urandom_range(0, 255)));
      end else if (pick < next_pct + 15) begin
        send_item(OP_FLUSH, BYTE_W'($urandom_range(0, 255)));
      end else if (pick < next_pct + 20) begin
        send_item(OP_IGNORED, BYTE_W'($urandom_range(0, 255)));
      end else begin
        send_sample();
      end
    end
  endtask

  initial begin
    int stall_left;
    ring_view_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_views.size() == 0) begin
          $error("unexpected result: available_count %0d, red_value %0h, ir_value %0h",
                 available_count, red_value, ir_value);
          mismatch_count++;
        end else begin
          want = pending_views.pop_front();
          if (available_count !== want.count) begin
            $error("available_count: expected %0d, got %0d", want.count, available_count);
            mismatch_count++;
          end
          if (red_value !== want.red) begin
            $error("red_value: expected %0h, got %0h", want.red, red_value);
            mismatch_count++;
          end
          if (ir_value !== want.ir) begin
            $error("ir_value: expected %0h, got %0h", want.ir, ir_value);
            mismatch_count++;
          end
          if (sample_stored !== want.stored) begin
            $error("sample_stored: expected %0d, got %0d", want.stored, sample_stored);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].b, directed_rows[i].typed,
                directed_rows[i].want);
    end
    send_mix(40, 15);
    // Enough whole samples in a row to wrap the write pointer past the read pointer.
    repeat (34) send_sample();
    send_mix(40, 55);
    idle_en = 1'b0;
    send_mix(15, 30);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("dual_channel_sample_ring_buffer_unit test passed");
    end else begin
      $display("dual_channel_sample_ring_buffer_unit test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("dual_channel_sample_ring_buffer_unit test failed");
    $finish;
  end

endmodule

// File: dual_channel_sample_ring_buffer_unit.f
+incdir+sv
sv/dcsrb_pkg.sv
sv/dcsrb_unpack.sv
sv/dcsrb_mem.sv
sv/dual_channel_sample_ring_buffer_unit.sv
verif/tb.sv
